@@ hdl/tdpr_pkg.sv @@
// Shared constants and types for the task device with power retention.
package tdpr_pkg;

   localparam int unsigned REG_BYTES_DEF  = 256;
   localparam int unsigned SET_BIT_DEF    = 0;
   localparam int unsigned WORK_BIT_DEF   = 1;
   localparam int unsigned FINISH_BIT_DEF = 2;

   localparam int unsigned CNT_W    = 33;
   localparam int unsigned CSR_IDXW = 3;
   localparam int unsigned OFF_EXTW = 13;

   localparam logic [2:0] KIND_READ      = 3'd0;
   localparam logic [2:0] KIND_WRITE     = 3'd1;
   localparam logic [2:0] KIND_TICK      = 3'd2;
   localparam logic [2:0] KIND_RET_BEGIN = 3'd3;
   localparam logic [2:0] KIND_POWER_OFF = 3'd4;
   localparam logic [2:0] KIND_RET_END   = 3'd5;
   localparam logic [2:0] KIND_POWER_ON  = 3'd6;

   localparam logic [1:0] PM_OFF    = 2'd0;
   localparam logic [1:0] PM_IDLE   = 2'd1;
   localparam logic [1:0] PM_ACTIVE = 2'd2;

   localparam logic [CSR_IDXW-1:0] CSR_SET_DELAY     = 3'd0;
   localparam logic [CSR_IDXW-1:0] CSR_WORK_DELAY    = 3'd1;
   localparam logic [CSR_IDXW-1:0] CSR_RECOVER_DELAY = 3'd2;
   localparam logic [CSR_IDXW-1:0] CSR_INIT_RESUME   = 3'd3;
   localparam logic [CSR_IDXW-1:0] CSR_INTERRUPTABLE = 3'd4;

   typedef struct packed {
      logic       irq_fired;
      logic       task_started;
      logic       request_rejected;
      logic [1:0] power_state;
   } ctl_result_type;

endpackage

@@ hdl/tdpr_mem.sv @@
// Byte storage memory with a clearing pass after reset.
module tdpr_mem #(
   parameter int unsigned REG_BYTES = tdpr_pkg::REG_BYTES_DEF,
   parameter int unsigned AW        = $clog2(REG_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   output logic [7:0]    rd_data,
   output logic          clearing
);
   import tdpr_pkg::*;

   logic [7:0]    mem [REG_BYTES];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic          clearing_ff, clearing_in;
   logic          we;
   logic [AW-1:0] wa;
   logic [7:0]    wd;

   always_comb begin
      clr_in      = clr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + AW'(1);
         if (clr_ff == AW'(REG_BYTES - 1)) clearing_in = 1'b0;
      end
      we = clearing_ff | wr_en;
      wa = clearing_ff ? clr_ff : wr_addr;
      wd = clearing_ff ? 8'd0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_ff      <= clr_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

@@ hdl/tdpr_ctrl.sv @@
// Control byte, power mode, countdown, saved count and configuration registers.
module tdpr_ctrl #(
   parameter int unsigned SET_BIT    = tdpr_pkg::SET_BIT_DEF,
   parameter int unsigned WORK_BIT   = tdpr_pkg::WORK_BIT_DEF,
   parameter int unsigned FINISH_BIT = tdpr_pkg::FINISH_BIT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [2:0]                      kind,
   input  logic [7:0]                      offset,
   input  logic [7:0]                      write_data,
   input  logic                            csr_we,
   input  logic [tdpr_pkg::CSR_IDXW-1:0]   csr_index,
   input  logic [31:0]                     csr_data,
   output tdpr_pkg::ctl_result_type        result,
   output logic [7:0]                      byte0
);
   import tdpr_pkg::*;

   localparam logic [7:0] SetMask    = 8'd1 << SET_BIT;
   localparam logic [7:0] WorkMask   = 8'd1 << WORK_BIT;
   localparam logic [7:0] FinishMask = 8'd1 << FINISH_BIT;

   logic [31:0]      set_delay_ff, work_delay_ff, recover_ff, init_resume_ff;
   logic             intr_ff;
   logic [7:0]       byte0_ff, byte0_in;
   logic [1:0]       pm_ff, pm_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_dec;
   logic             run_ff, run_in;
   logic [CNT_W-1:0] saved_ff, saved_in;
   logic [CNT_W-1:0] task_sum;
   logic             working;
   ctl_result_type   res;

   always_comb begin
      task_sum = {1'b0, set_delay_ff} + {1'b0, work_delay_ff};
      working  = (byte0_ff & WorkMask) != 8'd0;
      byte0_in = byte0_ff;
      pm_in    = pm_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      saved_in = saved_ff;
      cnt_dec  = (cnt_ff != '0) ? cnt_ff - CNT_W'(1) : cnt_ff;
      res      = '0;
      unique case (kind)
         KIND_WRITE: begin
            if (offset == 8'd0 && (write_data & SetMask) != 8'd0) begin
               if (working) begin
                  res.request_rejected = 1'b1;
               end else begin
                  pm_in    = PM_ACTIVE;
                  byte0_in = (byte0_ff | WorkMask) & ~FinishMask;
                  cnt_in   = task_sum;
                  run_in   = 1'b1;
                  res.task_started = 1'b1;
               end
            end
         end
         KIND_TICK: begin
            if (run_ff) begin
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  run_in   = 1'b0;
                  pm_in    = PM_IDLE;
                  byte0_in = (byte0_ff | FinishMask) & ~WorkMask;
                  res.irq_fired = 1'b1;
               end
            end
         end
         KIND_RET_BEGIN: begin
            pm_in = PM_OFF;
            if (working && run_ff) begin
               saved_in = cnt_ff;
               run_in   = 1'b0;
            end
         end
         KIND_POWER_OFF: begin
            if (working && !intr_ff) saved_in = task_sum;
         end
         KIND_RET_END, KIND_POWER_ON: begin
            pm_in = PM_IDLE;
            if (working) begin
               pm_in  = PM_ACTIVE;
               cnt_in = saved_ff;
               run_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.power_state = pm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_delay_ff   <= '0;
         work_delay_ff  <= '0;
         recover_ff     <= '0;
         init_resume_ff <= '0;
         intr_ff        <= 1'b0;
         byte0_ff       <= '0;
         pm_ff          <= PM_OFF;
         cnt_ff         <= '0;
         run_ff         <= 1'b0;
         saved_ff       <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SET_DELAY:     set_delay_ff  <= csr_data;
               CSR_WORK_DELAY:    work_delay_ff <= csr_data;
               CSR_RECOVER_DELAY: begin
                  recover_ff <= csr_data;
                  saved_ff   <= {1'b0, init_resume_ff} + {1'b0, csr_data};
               end
               CSR_INIT_RESUME: begin
                  init_resume_ff <= csr_data;
                  saved_ff       <= {1'b0, csr_data} + {1'b0, recover_ff};
               end
               CSR_INTERRUPTABLE: intr_ff <= csr_data[0];
               default: begin
               end
            endcase
         end else if (accept) begin
            saved_ff <= saved_in;
         end
         if (accept) begin
            byte0_ff <= byte0_in;
            pm_ff    <= pm_in;
            cnt_ff   <= cnt_in;
            run_ff   <= run_in;
         end
      end
   end

   assign result = res;
   assign byte0  = byte0_ff;

endmodule

@@ hdl/task_device_with_power_retention_unit.sv @@
// Pipeline: a request is registered in stage one (s1), then in the response register that
// drives rsp_tvalid; a stalled response holds stage one.
// Throughput: one request per cycle unless clearing or a stalled stage one holds req_tready low;
// control state updates in the accept cycle and the byte memory read port is registered.
// Reset: synchronous, active high; control state and registers clear at once, then a
// clearing pass writes zero to all REG_BYTES memory bytes, one per cycle, during which
// req_tready stays low (configuration writes are still taken).
module task_device_with_power_retention_unit #(
   parameter int unsigned REG_BYTES  = tdpr_pkg::REG_BYTES_DEF,
   parameter int unsigned SET_BIT    = tdpr_pkg::SET_BIT_DEF,
   parameter int unsigned WORK_BIT   = tdpr_pkg::WORK_BIT_DEF,
   parameter int unsigned FINISH_BIT = tdpr_pkg::FINISH_BIT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,  // offset[7:0], write_data[15:8]
   input  logic [2:0]                    req_tuser,  // req_type[2:0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // read_data[7:0], irq_fired[8], task_started[9], request_rejected[10],
   // power_state[12:11], zero[15:13]
   output logic [15:0]                   rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tdpr_pkg::CSR_IDXW-1:0] csr_index,
   input  logic [31:0]                   csr_data
);
   import tdpr_pkg::*;

   localparam int unsigned AW = $clog2(REG_BYTES);

   logic [7:0]          offset, write_data;
   logic [2:0]          kind;
   logic                accept, clearing;
   logic [OFF_EXTW-1:0] off_ext;
   logic                in_range;
   logic [AW-1:0]       addr;
   logic                mem_wr, mem_rd;
   logic [7:0]          mem_rdata, byte0;
   ctl_result_type      ctl_res;

   logic                s1_v_ff, s1_v_in, s1_adv;
   ctl_result_type      s1_res_ff;
   logic                s1_mem_ff;
   logic [7:0]          s1_byte_ff, s1_byte_in;
   logic                rsp_v_ff, rsp_v_in;
   logic [15:0]         rsp_data_ff;

   assign offset     = req_tdata[7:0];
   assign write_data = req_tdata[15:8];
   assign kind       = req_tuser;
   assign off_ext    = {{(OFF_EXTW - 8){1'b0}}, offset};
   assign in_range   = off_ext < OFF_EXTW'(REG_BYTES);
   assign addr       = off_ext[AW-1:0];

   assign s1_adv     = s1_v_ff && (!rsp_v_ff || rsp_tready);
   assign req_tready = !clearing && (!s1_v_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign mem_wr = accept && kind == KIND_WRITE && offset != 8'd0 && in_range;
   assign mem_rd = accept;
   assign s1_byte_in = (kind == KIND_READ && offset == 8'd0) ? byte0 : 8'd0;

   tdpr_mem #(
      .REG_BYTES (REG_BYTES),
      .AW        (AW)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (mem_rd),
      .rd_addr  (addr),
      .wr_en    (mem_wr),
      .wr_addr  (addr),
      .wr_data  (write_data),
      .rd_data  (mem_rdata),
      .clearing (clearing)
   );

   tdpr_ctrl #(
      .SET_BIT    (SET_BIT),
      .WORK_BIT   (WORK_BIT),
      .FINISH_BIT (FINISH_BIT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (kind),
      .offset     (offset),
      .write_data (write_data),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .result     (ctl_res),
      .byte0      (byte0)
   );

   always_comb begin
      s1_v_in = s1_v_ff;
      if (accept) s1_v_in = 1'b1;
      else if (s1_adv) s1_v_in = 1'b0;
      rsp_v_in = rsp_v_ff;
      if (s1_adv) rsp_v_in = 1'b1;
      else if (rsp_tready) rsp_v_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff  <= ctl_res;
         s1_mem_ff  <= kind == KIND_READ && offset != 8'd0 && in_range;
         s1_byte_ff <= s1_byte_in;
      end
      if (s1_adv) begin
         rsp_data_ff <= {3'b000, s1_res_ff.power_state, s1_res_ff.request_rejected,
                         s1_res_ff.task_started, s1_res_ff.irq_fired,
                         s1_mem_ff ? mem_rdata : s1_byte_ff};
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready)
      else $error("request taken during clearing pass");

   a_stalled_stage_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !s1_adv) |-> !req_tready)
      else $error("request taken while stage one is stalled");

   a_start_reject_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[9] && rsp_tdata[10]))
      else $error("start both taken and rejected");

   a_power_state_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[12:11] != 2'd3)
      else $error("illegal power state in result");

   a_result_follows_stage: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_tvalid)
      else $error("stage one transfer lost");

endmodule
